// ===== rtl/gsdbc_pkg.sv =====
// Shared constants, types and configuration codes for the gyro bias calibrator.
`timescale 1ns / 1ps
package gsdbc_pkg;

  localparam int WINDOW    = 100;
  localparam int WIN_LOG   = $clog2(WINDOW);
  localparam int SLOT_W    = WIN_LOG;
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = SAMPLE_W + WIN_LOG + 1;
  localparam int SQ_W      = 2 * SAMPLE_W - 1;
  localparam int SQS_W     = SQ_W + WIN_LOG;
  localparam int THR_W     = 30;
  localparam int SPR_W     = THR_W + 2 * WIN_LOG + 1;
  localparam int MAG_W     = SUM_W + 8;
  localparam int RECIP_W   = MAG_W - WIN_LOG + 1;
  localparam int REM_W     = WIN_LOG + 1;
  localparam int HALF_WIN  = WINDOW / 2;
  localparam int BIAS_W    = 24;
  localparam int RATE_W    = 25;
  localparam int CNT_W     = 7;
  localparam int QDEPTH    = 16;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int CREDIT_W  = $clog2(QDEPTH + 1);
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * RATE_W;

  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((64'd1 << MAG_W) / WINDOW);
  localparam logic [SPR_W-1:0]   WIN_SQ = SPR_W'(WINDOW * WINDOW);

  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(2147);
  localparam logic [CNT_W-1:0] SETTLE_RESET = CNT_W'(99);
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

  typedef enum logic [0:0] {
    CFG_VAR_THRESHOLD = 1'b0,
    CFG_SETTLE_COUNT  = 1'b1
  } cfg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [BIAS_W-1:0]   bias_t;

  typedef struct packed {
    sample_t [2:0] sample;
    bias_t   [2:0] mean;
    logic          upd;
    logic          full;
  } qitem_t;

endpackage

// ===== rtl/gsdbc_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
module gsdbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/gsdbc_front.sv =====
// Front end: accepts samples, keeps window statistics and decides on bias updates.
`timescale 1ns / 1ps
module gsdbc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  gsdbc_pkg::sample_t [2:0]           in_sample,
  input  logic [gsdbc_pkg::THR_W-1:0]        var_threshold,
  input  logic [gsdbc_pkg::CNT_W-1:0]        settle_count,
  input  logic                               q_pop,
  output logic                               q_push,
  output gsdbc_pkg::qitem_t                  q_item
);

  localparam int SLOT_W   = gsdbc_pkg::SLOT_W;
  localparam int SAMPLE_W = gsdbc_pkg::SAMPLE_W;
  localparam int SUM_W    = gsdbc_pkg::SUM_W;
  localparam int SQ_W     = gsdbc_pkg::SQ_W;
  localparam int SQS_W    = gsdbc_pkg::SQS_W;
  localparam int SPR_W    = gsdbc_pkg::SPR_W;
  localparam int MAG_W    = gsdbc_pkg::MAG_W;
  localparam int RECIP_W  = gsdbc_pkg::RECIP_W;
  localparam int REM_W    = gsdbc_pkg::REM_W;
  localparam int BIAS_W   = gsdbc_pkg::BIAS_W;
  localparam int CNT_W    = gsdbc_pkg::CNT_W;
  localparam int CREDIT_W = gsdbc_pkg::CREDIT_W;

  logic                   accept;
  logic                   slot_last;
  logic [SLOT_W-1:0]      slot_r;
  logic                   filled_r;
  logic [CREDIT_W-1:0]    credit_r;
  logic [3*SAMPLE_W-1:0]  old_word;
  logic [SPR_W-1:0]       lim_r;

  logic                    p1_valid_r, p1_sub_r, p1_full_r;
  gsdbc_pkg::sample_t [2:0] p1_sample_r;
  logic signed [SAMPLE_W-1:0] p1_old [3];

  logic                    p2_valid_r, p2_full_r;
  gsdbc_pkg::sample_t [2:0] p2_sample_r;
  logic [SQ_W-1:0]         p2_sqn_r [3];
  logic [SQ_W-1:0]         p2_sqo_r [3];

  logic                    p3_valid_r, p3_full_r;
  gsdbc_pkg::sample_t [2:0] p3_sample_r;
  logic [SPR_W-1:0]        p3_sum2_r [3];
  logic [MAG_W-1:0]        p3_mag_r [3];
  logic [2:0]              p3_neg_r;

  logic                    p4_valid_r, p4_full_r;
  gsdbc_pkg::sample_t [2:0] p4_sample_r;
  logic [SPR_W-1:0]        p4_spread_r [3];
  logic [MAG_W-1:0]        p4_mag_r [3];
  logic [RECIP_W-1:0]      p4_q0_r [3];
  logic [2:0]              p4_neg_r;

  logic                    p5_valid_r, p5_full_r, p5_still_r;
  gsdbc_pkg::sample_t [2:0] p5_sample_r;
  logic [RECIP_W-1:0]      p5_q0_r [3];
  logic [REM_W-1:0]        p5_rem_r [3];
  logic [2:0]              p5_neg_r;

  logic signed [SUM_W-1:0] sum_r [3];
  logic [SQS_W-1:0]        sumsq_r [3];
  logic [CNT_W-1:0]        cnt_r;

  logic                    upd;
  logic [CNT_W:0]          cnt_lim;

  assign in_ready  = rst_n && (credit_r < CREDIT_W'(gsdbc_pkg::QDEPTH));
  assign accept    = in_valid & in_ready;
  assign slot_last = slot_r == SLOT_W'(gsdbc_pkg::WINDOW - 1);

  gsdbc_ram #(
    .WIDTH (3 * SAMPLE_W),
    .DEPTH (gsdbc_pkg::WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (slot_r),
    .wdata (in_sample),
    .raddr (slot_r),
    .rdata (old_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      filled_r <= 1'b0;
      credit_r <= '0;
    end else begin
      if (accept) begin
        slot_r   <= slot_last ? '0 : slot_r + SLOT_W'(1);
        filled_r <= filled_r | slot_last;
      end
      credit_r <= credit_r + CREDIT_W'(accept) - CREDIT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    lim_r <= SPR_W'(var_threshold) * gsdbc_pkg::WIN_SQ;
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p1_old[a] = p1_sub_r ? $signed(old_word[a*SAMPLE_W +: SAMPLE_W]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
      p4_valid_r <= 1'b0;
      p5_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum_r[a]   <= '0;
        sumsq_r[a] <= '0;
      end
    end else begin
      p1_valid_r <= accept;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
      p4_valid_r <= p3_valid_r;
      p5_valid_r <= p4_valid_r;
      for (int a = 0; a < 3; a++) begin
        if (p1_valid_r) begin
          sum_r[a] <= sum_r[a] + SUM_W'($signed(p1_sample_r[a])) - SUM_W'(p1_old[a]);
        end
        if (p2_valid_r) begin
          sumsq_r[a] <= sumsq_r[a] + SQS_W'(p2_sqn_r[a]) - SQS_W'(p2_sqo_r[a]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [2*SAMPLE_W-1:0] sqn;
    logic signed [2*SAMPLE_W-1:0] sqo;
    logic signed [2*SUM_W-1:0]    s2;
    logic [SUM_W-1:0]             abs_sum;
    logic [MAG_W+RECIP_W-1:0]     prod;
    logic [MAG_W-1:0]             qw;
    logic [MAG_W-1:0]             rem;
    logic                         still;
    p1_sub_r    <= filled_r;
    p1_full_r   <= filled_r | slot_last;
    p1_sample_r <= in_sample;

    p2_full_r   <= p1_full_r;
    p2_sample_r <= p1_sample_r;

    p3_full_r   <= p2_full_r;
    p3_sample_r <= p2_sample_r;

    p4_full_r   <= p3_full_r;
    p4_sample_r <= p3_sample_r;
    p4_neg_r    <= p3_neg_r;

    p5_full_r   <= p4_full_r;
    p5_sample_r <= p4_sample_r;
    p5_neg_r    <= p4_neg_r;

    still = p4_full_r;
    for (int a = 0; a < 3; a++) begin
      sqn = $signed(p1_sample_r[a]) * $signed(p1_sample_r[a]);
      sqo = p1_old[a] * p1_old[a];
      p2_sqn_r[a] <= sqn[SQ_W-1:0];
      p2_sqo_r[a] <= sqo[SQ_W-1:0];

      s2 = sum_r[a] * sum_r[a];
      abs_sum = sum_r[a][SUM_W-1] ? SUM_W'(-sum_r[a]) : SUM_W'(sum_r[a]);
      p3_sum2_r[a] <= s2[SPR_W-1:0];
      p3_neg_r[a]  <= sum_r[a][SUM_W-1];
      p3_mag_r[a]  <= {abs_sum, 8'h00} + MAG_W'(gsdbc_pkg::HALF_WIN);

      p4_spread_r[a] <= SPR_W'(sumsq_r[a]) * SPR_W'(gsdbc_pkg::WINDOW) - p3_sum2_r[a];
      prod = (MAG_W+RECIP_W)'(p3_mag_r[a]) * (MAG_W+RECIP_W)'(gsdbc_pkg::RECIP);
      p4_q0_r[a]  <= prod[MAG_W+RECIP_W-1:MAG_W];
      p4_mag_r[a] <= p3_mag_r[a];

      qw = MAG_W'(p4_q0_r[a]) * MAG_W'(gsdbc_pkg::WINDOW);
      rem = p4_mag_r[a] - qw;
      p5_rem_r[a] <= rem[REM_W-1:0];
      p5_q0_r[a]  <= p4_q0_r[a];
      still = still & (p4_spread_r[a] < lim_r);
    end
    p5_still_r <= still;
  end

  assign upd     = p5_still_r && (cnt_r >= settle_count);
  assign cnt_lim = (settle_count == gsdbc_pkg::CNT_MAX) ? {1'b0, gsdbc_pkg::CNT_MAX}
                                                        : {1'b0, settle_count} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (p5_valid_r) begin
      if (upd) begin
        cnt_r <= '0;
      end else if ({1'b0, cnt_r} < cnt_lim) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    logic [BIAS_W-1:0] q;
    q_item.sample = p5_sample_r;
    q_item.upd    = upd;
    q_item.full   = p5_full_r;
    for (int a = 0; a < 3; a++) begin
      q = BIAS_W'(p5_q0_r[a]) + BIAS_W'(p5_rem_r[a] >= REM_W'(gsdbc_pkg::WINDOW));
      q_item.mean[a] = p5_neg_r[a] ? -q : q;
    end
  end

  assign q_push = p5_valid_r;

endmodule

// ===== rtl/gsdbc_fifo.sv =====
// Short queue between the statistics front end and the output back end.
`timescale 1ns / 1ps
module gsdbc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gsdbc_pkg::qitem_t wdata,
  input  logic              pop,
  output gsdbc_pkg::qitem_t rdata,
  output logic              empty
);

  localparam int QPTR_W   = gsdbc_pkg::QPTR_W;
  localparam int CREDIT_W = gsdbc_pkg::CREDIT_W;

  gsdbc_pkg::qitem_t    mem [gsdbc_pkg::QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [CREDIT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CREDIT_W'(push) - CREDIT_W'(pop);
    end
  end

  assign rdata = mem[rd_ptr_r];
  assign empty = count_r == '0;

endmodule

// ===== rtl/gsdbc_back.sv =====
// Back end: applies bias updates and drives the registered result stream.
`timescale 1ns / 1ps
module gsdbc_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  gsdbc_pkg::qitem_t                     q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0][gsdbc_pkg::RATE_W-1:0]     out_rate,
  output logic                                  out_upd,
  output logic                                  out_full
);

  localparam int RATE_W = gsdbc_pkg::RATE_W;

  gsdbc_pkg::bias_t [2:0]       bias_r;
  gsdbc_pkg::bias_t [2:0]       bias_nxt;
  logic                         out_valid_r;
  logic [2:0][RATE_W-1:0]       rate_r;
  logic                         upd_r;
  logic                         full_r;

  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      bias_nxt[a] = q_item.upd ? q_item.mean[a] : bias_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bias_r      <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        bias_r      <= bias_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int a = 0; a < 3; a++) begin
        rate_r[a] <= {q_item.sample[a][gsdbc_pkg::SAMPLE_W-1], q_item.sample[a], 8'h00}
                     - {bias_nxt[a][gsdbc_pkg::BIAS_W-1], bias_nxt[a]};
      end
      upd_r  <= q_item.upd;
      full_r <= q_item.full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rate  = rate_r;
  assign out_upd   = upd_r;
  assign out_full  = full_r;

endmodule

// ===== rtl/gyro_still_detect_bias_calibrator_unit.sv =====
// Top level of the gyro still detector and zero-rate bias calibrator.
`timescale 1ns / 1ps
// Each request carries one three-axis gyro sample; each result carries the three rates
// minus the current bias in 8 fraction bits, a flag that marks a bias update (reset
// downstream integrators on it) and a flag that the sample window has been filled once.
// The block takes one request per cycle while its result queue has credit left, and returns
// one result per request, in order, through the front-end pipeline, the queue and the output
// register. The window RAM does one read and one write of the per-axis samples per request;
// the window needs no clearing after reset. The user must write configuration only while
// no request is in flight; the block itself does not enforce this.
module gyro_still_detect_bias_calibrator_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // gyro_x [15:0], gyro_y [31:16], gyro_z [47:32]
  input  logic [gsdbc_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // rate_x [24:0], rate_y [49:25], rate_z [74:50], zero [79:75]
  output logic [gsdbc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // bias_updated [0], window_full [1]
  output logic [1:0]                            out_tuser,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [gsdbc_pkg::THR_W-1:0]           cfg_wdata
);

  logic [gsdbc_pkg::THR_W-1:0]           thr_r;
  logic [gsdbc_pkg::CNT_W-1:0]           settle_r;
  gsdbc_pkg::sample_t [2:0]              in_sample;
  logic                                  q_push;
  logic                                  q_pop;
  logic                                  q_empty;
  gsdbc_pkg::qitem_t                     q_wdata;
  gsdbc_pkg::qitem_t                     q_rdata;
  logic [2:0][gsdbc_pkg::RATE_W-1:0]     out_rate;
  logic                                  out_upd;
  logic                                  out_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= gsdbc_pkg::THR_RESET;
      settle_r <= gsdbc_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      unique case (gsdbc_pkg::cfg_idx_t'(cfg_index))
        gsdbc_pkg::CFG_VAR_THRESHOLD: thr_r    <= cfg_wdata;
        gsdbc_pkg::CFG_SETTLE_COUNT:  settle_r <= cfg_wdata[gsdbc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_sample = in_tdata;

  gsdbc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_sample     (in_sample),
    .var_threshold (thr_r),
    .settle_count  (settle_r),
    .q_pop         (q_pop),
    .q_push        (q_push),
    .q_item        (q_wdata)
  );

  gsdbc_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  gsdbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rate  (out_rate),
    .out_upd   (out_upd),
    .out_full  (out_full)
  );

  assign out_tdata = {{gsdbc_pkg::OUT_PAD_W{1'b0}}, out_rate};
  assign out_tuser = {out_full, out_upd};

endmodule

// ===== test/gyro_still_detect_bias_calibrator_unit_tb.sv =====
// Self-checking testbench for the gyro still detector and bias calibrator with its rate scoreboard.
`timescale 1ns / 1ps
module gyro_still_detect_bias_calibrator_unit_tb;
  import gsdbc_pkg::*;

  typedef struct packed {
    logic [RATE_W-1:0] rate_z;
    logic [RATE_W-1:0] rate_y;
    logic [RATE_W-1:0] rate_x;
    logic              full;
    logic              upd;
  } rate_result_t;

  class rate_scoreboard;
    longint       var_limit = THR_RESET;
    int           settle_target = SETTLE_RESET;
    int           win_store [3][WINDOW];
    longint       sums [3];
    longint       sq_sums [3];
    int           slot;
    bit           filled;
    int           settle_cnt;
    int           bias_q8 [3];
    rate_result_t expected_rates [$];
    int           fails;
    int           results;
    int           reported;

    function void set_reg(cfg_idx_t idx, logic [THR_W-1:0] val);
      case (idx)
        CFG_VAR_THRESHOLD: var_limit = val;
        CFG_SETTLE_COUNT: settle_target = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int round_mean(longint sum);
      longint scaled;
      longint mag;
      longint q;
      scaled = sum * 256;
      mag = (scaled < 0) ? -scaled : scaled;
      q = (mag + WINDOW / 2) / WINDOW;
      return (scaled < 0) ? -int'(q) : int'(q);
    endfunction

    function void note_sample(sample_t gx, sample_t gy, sample_t gz);
      int           smp [3];
      int           old;
      int           cap;
      bit           still;
      longint       spread;
      rate_result_t e;
      smp[0] = gx;
      smp[1] = gy;
      smp[2] = gz;
      for (int a = 0; a < 3; a++) begin
        if (filled) begin
          old = win_store[a][slot];
          sums[a] -= old;
          sq_sums[a] -= longint'(old) * old;
        end
        win_store[a][slot] = smp[a];
        sums[a] += smp[a];
        sq_sums[a] += longint'(smp[a]) * smp[a];
      end
      slot++;
      if (slot >= WINDOW) begin
        slot = 0;
        filled = 1'b1;
      end
      still = filled;
      for (int a = 0; a < 3; a++) begin
        spread = WINDOW * sq_sums[a] - sums[a] * sums[a];
        if (spread >= var_limit * WINDOW * WINDOW) still = 1'b0;
      end
      e.upd = 1'b0;
      if (still && settle_cnt >= settle_target) begin
        for (int a = 0; a < 3; a++) bias_q8[a] = round_mean(sums[a]);
        settle_cnt = 0;
        e.upd = 1'b1;
      end else begin
        cap = settle_target + 1;
        if (cap > 127) cap = 127;
        if (settle_cnt < cap) settle_cnt++;
      end
      e.rate_x = RATE_W'(smp[0] * 256 - bias_q8[0]);
      e.rate_y = RATE_W'(smp[1] * 256 - bias_q8[1]);
      e.rate_z = RATE_W'(smp[2] * 256 - bias_q8[2]);
      e.full = filled;
      expected_rates.push_back(e);
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        fails++;
        if (reported < 40) begin
          reported++;
          $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
        end
      end
    endfunction

    function void check_rates(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser);
      rate_result_t e;
      results++;
      if (expected_rates.size() == 0) begin
        fails++;
        $display("%0t result with no request pending: expected none actual %h/%b",
                 $time, tdata, tuser);
        return;
      end
      e = expected_rates.pop_front();
      compare_field("rate_x", $signed(e.rate_x), $signed(tdata[RATE_W-1:0]));
      compare_field("rate_y", $signed(e.rate_y), $signed(tdata[2*RATE_W-1:RATE_W]));
      compare_field("rate_z", $signed(e.rate_z), $signed(tdata[3*RATE_W-1:2*RATE_W]));
      compare_field("bias_updated", e.upd, tuser[0]);
      compare_field("window_full", e.full, tuser[1]);
    endfunction
  endclass

  localparam logic [IN_TDATA_W-1:0] CORNER_PATS [12] = '{
    48'h0000_0000_0000, 48'h7fff_7fff_7fff, 48'h8000_8000_8000, 48'hffff_ffff_ffff,
    48'h0001_0001_0001, 48'h8000_7fff_0000, 48'h7fff_0000_8000, 48'h0000_8000_7fff,
    48'h5555_aaaa_5555, 48'haaaa_5555_aaaa, 48'h8001_fffe_0002, 48'h7ffe_8001_ffff
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_we;
  logic                   cfg_index;
  logic [THR_W-1:0]       cfg_wdata;

  rate_scoreboard sb = new();
  int             send_burst_left;

  gyro_still_detect_bias_calibrator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(input sample_t gx, input sample_t gy, input sample_t gz);
    int gap;
    if (send_burst_left > 0) begin
      gap = 0;
      send_burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 4) send_burst_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {gz, gy, gx};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(gx, gy, gz);
  endtask

  task automatic drain_requests();
    in_tvalid <= 1'b0;
    while (sb.expected_rates.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [THR_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic run_still(input int n, input int amp);
    int      base [3];
    int      seg;
    sample_t smp [3];
    seg = 0;
    for (int i = 0; i < n; i++) begin
      if (seg == 0) begin
        seg = $urandom_range(150, 300);
        for (int a = 0; a < 3; a++)
          base[a] = int'($urandom_range(0, 65535 - 2 * amp)) - 32768 + amp;
      end
      seg--;
      for (int a = 0; a < 3; a++)
        smp[a] = sample_t'(base[a] + int'($urandom_range(0, 2 * amp)) - amp);
      if ($urandom_range(0, 99) < 2) smp[$urandom_range(0, 2)] = sample_t'($urandom);
      send_sample(smp[0], smp[1], smp[2]);
    end
  endtask

  task automatic run_const(input int n, input sample_t val);
    for (int i = 0; i < n; i++) send_sample(val, val, val);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++)
      send_sample(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
  endtask

  initial begin : result_sink
    int  stall_left;
    int  burst_left;
    bit  hold_done;
    stall_left = 0;
    burst_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_rates(out_tdata, out_tuser);
      if (!hold_done && sb.results >= 40) begin
        hold_done = 1'b1;
        stall_left = $urandom_range(150, 250);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 99) < 5) begin
          burst_left = $urandom_range(30, 100);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin : stimulus
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_VAR_THRESHOLD;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    send_burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (CORNER_PATS[i])
      send_sample(CORNER_PATS[i][15:0], CORNER_PATS[i][31:16], CORNER_PATS[i][47:32]);
    run_still(250, 30);
    drain_requests();

    write_reg(CFG_VAR_THRESHOLD, {THR_W{1'b1}});
    write_reg(CFG_SETTLE_COUNT, '0);
    run_const(110, 16'sh8000);
    run_const(110, 16'sh7fff);
    run_random(100);
    drain_requests();

    write_reg(CFG_VAR_THRESHOLD, '0);
    write_reg(CFG_SETTLE_COUNT, 126);
    run_still(120, 10);
    drain_requests();

    write_reg(CFG_VAR_THRESHOLD, $urandom_range(200, 20000));
    write_reg(CFG_SETTLE_COUNT, $urandom_range(0, 20));
    run_still(150, $urandom_range(10, 90));
    drain_requests();

    write_reg(CFG_VAR_THRESHOLD, THR_RESET);
    write_reg(CFG_SETTLE_COUNT, $urandom_range(1, 10));
    run_still(100, 25);
    drain_requests();

    if (sb.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
